FILE: design/ordered_array_list_engine_core_defines.svh
// assertion macros used by the ordered list engine core
`ifndef ORDERED_ARRAY_LIST_ENGINE_CORE_DEFINES_SVH
`define ORDERED_ARRAY_LIST_ENGINE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// plain property checked on every clock outside reset
`define OALE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// same-cycle implication checked on every clock outside reset
`define OALE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define OALE_ASSERT(lbl, prop, msg)
`define OALE_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

FILE: design/oale_pkg.sv
// shared types and constants of the ordered list engine
package oale_pkg;

  // default sizing
  localparam int CAPACITY_DEF   = 64;
  localparam int WORD_WIDTH_DEF = 32;

  // request and result field widths
  localparam int OP_W     = 3;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 32;
  localparam int FPOS_W   = 6;
  localparam int LEN_W    = 7;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_LOCATE = 3'd2,
    OP_GET    = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // broadcast controls for every cell
  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic scan_locate;
  } cell_ctrl_t;

  // scan token passed cell to cell
  typedef struct packed {
    logic vld;
    logic hit;
  } scan_tok_t;

endpackage

FILE: design/oale_cell.sv
// one list cell: holds an entry, shifts with its neighbors, forwards the scan token
module oale_cell #(
  parameter int WORD_WIDTH = oale_pkg::WORD_WIDTH_DEF,
  parameter int IDX_WIDTH  = 6,
  parameter int CMP_WIDTH  = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  oale_pkg::cell_ctrl_t   ctrl_i,
  input  logic [IDX_WIDTH-1:0]   cell_idx_i,
  input  logic [CMP_WIDTH-1:0]   pos_i,
  input  logic [CMP_WIDTH-1:0]   count_i,
  input  logic [WORD_WIDTH-1:0]  value_i,
  input  logic [WORD_WIDTH-1:0]  left_word_i,
  input  logic [WORD_WIDTH-1:0]  right_word_i,
  output logic [WORD_WIDTH-1:0]  word_o,
  input  oale_pkg::scan_tok_t    scan_i,
  input  logic [WORD_WIDTH-1:0]  scan_word_i,
  input  logic [IDX_WIDTH-1:0]   scan_idx_i,
  output oale_pkg::scan_tok_t    scan_o,
  output logic [WORD_WIDTH-1:0]  scan_word_o,
  output logic [IDX_WIDTH-1:0]   scan_idx_o
);

  logic [WORD_WIDTH-1:0] word_d, word_q;
  oale_pkg::scan_tok_t   tok_d, tok_q;
  logic [WORD_WIDTH-1:0] sword_d, sword_q;
  logic [IDX_WIDTH-1:0]  sidx_d, sidx_q;
  logic [CMP_WIDTH-1:0]  idx_x;
  logic                  occupied;
  logic                  is_match;
  logic                  take;

  assign idx_x    = CMP_WIDTH'(cell_idx_i);
  assign occupied = idx_x < count_i;
  assign is_match = ctrl_i.scan_locate ? (word_q == value_i) : (idx_x == pos_i);

  // entry update on insert or delete
  always_comb begin
    word_d = word_q;
    if (ctrl_i.shift_up) begin
      if (idx_x > pos_i) begin
        word_d = left_word_i;
      end else if (idx_x == pos_i) begin
        word_d = value_i;
      end
    end else if (ctrl_i.shift_down && (idx_x >= pos_i)) begin
      word_d = right_word_i;
    end
  end

  // first occupied matching cell claims the token
  always_comb begin
    take      = scan_i.vld && !scan_i.hit && occupied && is_match;
    tok_d.vld = scan_i.vld;
    tok_d.hit = scan_i.hit | take;
    sword_d   = take ? word_q : scan_word_i;
    sidx_d    = take ? cell_idx_i : scan_idx_i;
  end

  // entry and token payload
  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    sword_q <= sword_d;
    sidx_q  <= sidx_d;
  end

  // token flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign word_o      = word_q;
  assign scan_o      = tok_q;
  assign scan_word_o = sword_q;
  assign scan_idx_o  = sidx_q;

endmodule

FILE: design/ordered_array_list_engine_core.sv
// Ordered list engine top level: a row of CAPACITY cells, one entry per cell. Insert, clear and
// unused op codes finish in the cycle they are accepted, with the result registered, so back to
// back requests of that kind can follow straight on while their results are taken. Delete, get
// and locate send a scan token down the cell row, one cell per cycle, and the result is
// registered when the token leaves the last cell; no new request is taken until then. One
// request is in flight at a time; a new request is taken only while the result slot is empty or
// its result is taken in the same cycle, so a result that waits stalls the input. Entries hold
// no reset value; only stored positions are ever read.
`include "ordered_array_list_engine_core_defines.svh"
module ordered_array_list_engine_core #(
  parameter int CAPACITY   = oale_pkg::CAPACITY_DEF,
  parameter int WORD_WIDTH = oale_pkg::WORD_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // op[2:0], position[9:3], item_value[41:10], zero fill
  input  logic [oale_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status[1:0], word_out[33:2], found_position[39:34], list_length[46:40], zero fill
  output logic [oale_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CMP_W     = (CNT_W > oale_pkg::POS_W) ? CNT_W : oale_pkg::POS_W;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                       state_d, state_q;
  logic                       start_d, start_q;
  logic [CNT_W-1:0]           count_d, count_q;
  oale_pkg::op_e              op_d, op_q;
  logic [CMP_W-1:0]           pos_d, pos_q;
  logic [WORD_WIDTH-1:0]      val_d, val_q;
  logic                       m_valid_d, m_valid_q;
  logic [oale_pkg::OUT_DATA_W-1:0] m_data_d, m_data_q;

  logic                       accept;
  oale_pkg::op_e              in_op;
  logic [oale_pkg::POS_W-1:0] in_pos;
  logic signed [oale_pkg::VAL_W-1:0] in_val;
  logic [WORD_WIDTH-1:0]      in_word;
  logic [CMP_W-1:0]           pos_x;
  logic [CMP_W-1:0]           cnt_x;
  logic [CMP_W-1:0]           pos_bc;
  logic [WORD_WIDTH-1:0]      val_bc;
  oale_pkg::cell_ctrl_t       ctrl;

  logic                       res_load;
  oale_pkg::status_e          res_status;
  logic [oale_pkg::WORD_W-1:0] res_word;
  logic [oale_pkg::FPOS_W-1:0] res_fpos;

  logic [WORD_WIDTH-1:0]      cell_word [CAPACITY];
  oale_pkg::scan_tok_t        tok       [CAPACITY];
  logic [WORD_WIDTH-1:0]      tok_word  [CAPACITY];
  logic [IDX_W-1:0]           tok_idx   [CAPACITY];
  logic [CAPACITY-1:0]        tok_vld;
  oale_pkg::scan_tok_t        last_tok;

  // request unpacking
  assign accept  = s_axis_tvalid & s_axis_tready;
  assign in_op   = oale_pkg::op_e'(s_axis_tdata[2:0]);
  assign in_pos  = s_axis_tdata[9:3];
  assign in_val  = s_axis_tdata[41:10];
  assign in_word = WORD_WIDTH'(in_val);
  assign pos_x   = CMP_W'(in_pos);
  assign cnt_x   = CMP_W'(count_q);

  // one request in flight, result slot must be free or freeing
  assign s_axis_tready = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready);

  // broadcast to the cells
  assign pos_bc   = (state_q == ST_IDLE) ? pos_x : pos_q;
  assign val_bc   = (state_q == ST_IDLE) ? in_word : val_q;
  assign last_tok = tok[CAPACITY-1];

  // control and result selection
  always_comb begin
    state_d          = state_q;
    start_d          = 1'b0;
    count_d          = count_q;
    op_d             = op_q;
    pos_d            = pos_q;
    val_d            = val_q;
    ctrl             = '0;
    ctrl.scan_locate = (op_q == oale_pkg::OP_LOCATE);
    res_load         = 1'b0;
    res_status       = oale_pkg::ST_OK;
    res_word         = '0;
    res_fpos         = '0;
    if (state_q == ST_IDLE) begin
      if (accept) begin
        unique case (in_op)
          oale_pkg::OP_INSERT: begin
            res_load = 1'b1;
            priority if (pos_x > cnt_x) begin
              res_status = oale_pkg::ST_RANGE;
            end else if (count_q >= CNT_W'(CAPACITY)) begin
              res_status = oale_pkg::ST_FULL;
            end else begin
              ctrl.shift_up = 1'b1;
              count_d       = count_q + 1'b1;
            end
          end
          oale_pkg::OP_DELETE, oale_pkg::OP_LOCATE, oale_pkg::OP_GET: begin
            state_d = ST_SCAN;
            start_d = 1'b1;
            op_d    = in_op;
            pos_d   = pos_x;
            val_d   = in_word;
          end
          oale_pkg::OP_CLEAR: begin
            res_load = 1'b1;
            count_d  = '0;
          end
          default: begin
            res_load = 1'b1;
          end
        endcase
      end
    end else if (last_tok.vld) begin
      state_d  = ST_IDLE;
      res_load = 1'b1;
      unique case (op_q)
        oale_pkg::OP_LOCATE: begin
          if (last_tok.hit) begin
            res_fpos = oale_pkg::FPOS_W'(tok_idx[CAPACITY-1]);
          end else begin
            res_status = oale_pkg::ST_NOT_FOUND;
          end
        end
        oale_pkg::OP_DELETE: begin
          if (last_tok.hit) begin
            res_word        = oale_pkg::WORD_W'(tok_word[CAPACITY-1]);
            ctrl.shift_down = 1'b1;
            count_d         = count_q - 1'b1;
          end else begin
            res_status = oale_pkg::ST_RANGE;
          end
        end
        default: begin
          if (last_tok.hit) begin
            res_word = oale_pkg::WORD_W'(tok_word[CAPACITY-1]);
          end else begin
            res_status = oale_pkg::ST_RANGE;
          end
        end
      endcase
    end
  end

  // result register
  always_comb begin
    m_valid_d = res_load | (m_valid_q & ~m_axis_tready);
    m_data_d  = m_data_q;
    if (res_load) begin
      m_data_d = oale_pkg::OUT_DATA_W'({oale_pkg::LEN_W'(count_d), res_fpos, res_word,
                                        res_status});
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      start_q   <= 1'b0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      start_q   <= start_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_w;
    logic [WORD_WIDTH-1:0] right_w;
    oale_pkg::scan_tok_t   tok_in;
    logic [WORD_WIDTH-1:0] word_in;
    logic [IDX_W-1:0]      idx_in;

    if (g == 0) begin : g_head
      assign left_w  = val_bc;
      assign tok_in  = '{vld: start_q, hit: 1'b0};
      assign word_in = '0;
      assign idx_in  = '0;
    end else begin : g_body
      assign left_w  = cell_word[g-1];
      assign tok_in  = tok[g-1];
      assign word_in = tok_word[g-1];
      assign idx_in  = tok_idx[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = cell_word[g];
    end else begin : g_inner
      assign right_w = cell_word[g+1];
    end

    oale_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .IDX_WIDTH  (IDX_W),
      .CMP_WIDTH  (CMP_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .cell_idx_i   (IDX_W'(g)),
      .pos_i        (pos_bc),
      .count_i      (cnt_x),
      .value_i      (val_bc),
      .left_word_i  (left_w),
      .right_word_i (right_w),
      .word_o       (cell_word[g]),
      .scan_i       (tok_in),
      .scan_word_i  (word_in),
      .scan_idx_i   (idx_in),
      .scan_o       (tok[g]),
      .scan_word_o  (tok_word[g]),
      .scan_idx_o   (tok_idx[g])
    );

    assign tok_vld[g] = tok[g].vld;
  end

  // checks
  `OALE_ASSERT_IMP(a_ready_only_idle, s_axis_tready, state_q == ST_IDLE, "ready while scanning")
  `OALE_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "length above capacity")
  `OALE_ASSERT(a_single_token, $countones(tok_vld) <= 1, "more than one scan token")
  `OALE_ASSERT_IMP(a_scan_slot_free, state_q == ST_SCAN, !m_valid_q, "result slot busy in scan")

endmodule
